// ----- rtl/lev_pkg.sv -----
package lev_pkg;

  localparam int CH_W   = 8;
  localparam int DIST_W = 7;

  // Word selector carried by every input beat.
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_CAND  = 1'b1;

  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] ch;
    logic            has_char;
    logic            last;
  } lev_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } lev_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_RDRES,
    ST_EMIT
  } lev_state_t;

endpackage

// ----- rtl/lev_ram.sv -----
module lev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lev_cell.sv -----
module lev_cell import lev_pkg::*; #(
  parameter int DW = 7
) (
  input  logic            first,
  input  logic [DW-1:0]   cand_len,
  input  logic [DW-1:0]   above,
  input  logic [DW-1:0]   left,
  input  logic [DW-1:0]   diag,
  input  logic [CH_W-1:0] q_ch,
  input  logic [CH_W-1:0] c_ch,
  output logic [DW-1:0]   value
);

  logic [DW:0] del_c;
  logic [DW:0] ins_c;
  logic [DW:0] sub_c;
  logic [DW:0] m1;
  logic [DW:0] m2;

  // Cell value is the cheapest of deletion, insertion and substitution; the first cell of the row takes cand_len + 1.
  always_comb begin
    del_c = {1'b0, above} + (DW+1)'(1);
    ins_c = {1'b0, left} + (DW+1)'(1);
    sub_c = {1'b0, diag} + ((q_ch == c_ch) ? (DW+1)'(0) : (DW+1)'(1));
    m1    = (del_c < ins_c) ? del_c : ins_c;
    m2    = (m1 < sub_c) ? m1 : sub_c;
    if (first) begin
      value = cand_len + DW'(1);
    end else begin
      value = m2[DW-1:0];
    end
  end

endmodule

// ----- rtl/levenshtein_edit_distance.sv -----
// Levenshtein distance engine. Query beats (op = 0) load the query word into a character
// memory, one beat per cycle while the engine is idle; the beat with last set closes the
// query, and a beat without a character allows an empty word. Candidate beats (op = 1)
// are scored against the query through one DP row held in a second memory: each candidate
// character sweeps the row one cell per cycle, and the candidate beat with last set then
// reads the final cell and emits the distance. Query beats and candidate beats without a
// character need no sweep. The sweep over the row memory sets the rate. A query or
// candidate longer than MAX_LEN characters sets overflow and the distance reads MAX_LEN.
// Any query beat abandons a candidate in progress. The row needs no clearing pass: a flag
// marks the freshly reset row, whose entry i reads as i until the first sweep overwrites
// it. A finished result waits in the output register while new beats are taken.
module levenshtein_edit_distance import lev_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lev_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lev_out_t out_data
);

  // Widths of lengths and row values (0 .. MAX_LEN) and of query addresses.
  localparam int DW  = $clog2(MAX_LEN + 1);
  localparam int QAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int EW  = (DW > DIST_W) ? DW : DIST_W;

  lev_state_t state_r, state_nxt;

  logic [DW-1:0]   idx_r, idx_nxt;
  logic [DW-1:0]   left_r, left_nxt;
  logic [DW-1:0]   diag_r, diag_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic            last_r, last_nxt;
  logic            row_init_r, row_init_nxt;
  logic [DW-1:0]   cand_len_r, cand_len_nxt;
  logic            ovf_r, ovf_nxt;
  logic [DW-1:0]   query_len_r, query_len_nxt;
  logic            query_open_r, query_open_nxt;
  logic            query_over_r, query_over_nxt;
  logic            out_valid_r, out_valid_nxt;
  lev_out_t        out_data_r, out_data_nxt;

  logic            accept;
  logic [DW-1:0]   qlen_base;
  logic            qover_base;

  logic            q_we;
  logic [QAW-1:0]  q_waddr;
  logic [QAW-1:0]  q_raddr;
  logic [CH_W-1:0] q_rdata;

  logic            dp_we;
  logic            dp_re;
  logic [DW-1:0]   dp_raddr;
  logic [DW-1:0]   dp_rdata;

  logic [DW-1:0]   above;
  logic [DW-1:0]   cell_val;
  logic [DW-1:0]   dist_sat;
  logic [EW-1:0]   dist_ext;

  lev_ram #(
    .WIDTH (CH_W),
    .DEPTH (MAX_LEN)
  ) u_query_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (in_data.ch),
    .re    (1'b1),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  lev_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_LEN + 1)
  ) u_row_ram (
    .clk   (clk),
    .we    (dp_we),
    .waddr (idx_r),
    .wdata (cell_val),
    .re    (dp_re),
    .raddr (dp_raddr),
    .rdata (dp_rdata)
  );

  // A freshly reset row reads entry i as i.
  assign above = row_init_r ? idx_r : dp_rdata;

  lev_cell #(
    .DW (DW)
  ) u_cell (
    .first    (idx_r == '0),
    .cand_len (cand_len_r),
    .above    (above),
    .left     (left_r),
    .diag     (diag_r),
    .q_ch     (q_rdata),
    .c_ch     (ch_r),
    .value    (cell_val)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The first query beat after a closed query starts a fresh word.
  assign qlen_base  = query_open_r ? query_len_r : '0;
  assign qover_base = query_open_r ? query_over_r : 1'b0;

  assign q_we    = accept && (in_data.op == OP_QUERY) && in_data.has_char &&
                   (qlen_base < DW'(MAX_LEN));
  assign q_waddr = qlen_base[QAW-1:0];

  // Distance of the finished candidate, saturated at MAX_LEN and extended to EW bits.
  always_comb begin
    if (ovf_r) begin
      dist_sat = DW'(MAX_LEN);
    end else if (row_init_r) begin
      dist_sat = query_len_r;
    end else if (dp_rdata > DW'(MAX_LEN)) begin
      dist_sat = DW'(MAX_LEN);
    end else begin
      dist_sat = dp_rdata;
    end
    dist_ext = EW'(dist_sat);
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    left_nxt       = left_r;
    diag_nxt       = diag_r;
    ch_nxt         = ch_r;
    last_nxt       = last_r;
    row_init_nxt   = row_init_r;
    cand_len_nxt   = cand_len_r;
    ovf_nxt        = ovf_r;
    query_len_nxt  = query_len_r;
    query_open_nxt = query_open_r;
    query_over_nxt = query_over_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    dp_we          = 1'b0;
    dp_re          = 1'b1;
    dp_raddr       = '0;
    q_raddr        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_QUERY) begin
            query_len_nxt  = qlen_base;
            query_over_nxt = qover_base;
            if (in_data.has_char) begin
              if (qlen_base < DW'(MAX_LEN)) begin
                query_len_nxt = qlen_base + DW'(1);
              end else begin
                query_over_nxt = 1'b1;
              end
            end
            query_open_nxt = !in_data.last;
            // Any query beat drops the candidate in progress.
            row_init_nxt   = 1'b1;
            cand_len_nxt   = '0;
            ovf_nxt        = query_over_nxt;
          end else begin
            ch_nxt   = in_data.ch;
            last_nxt = in_data.last;
            idx_nxt  = '0;
            if (in_data.has_char && (cand_len_r < DW'(MAX_LEN))) begin
              // Row entry 0 is being read this cycle.
              state_nxt = ST_ROW;
            end else begin
              if (in_data.has_char) begin
                ovf_nxt = 1'b1;
              end
              if (in_data.last) begin
                state_nxt = ST_RDRES;
              end
            end
          end
        end
      end

      ST_ROW: begin
        // Old entry idx is on the read port; write its new value back.
        dp_we    = 1'b1;
        left_nxt = cell_val;
        diag_nxt = above;
        dp_raddr = idx_r + DW'(1);
        q_raddr  = idx_r[QAW-1:0];
        if (idx_r == query_len_r) begin
          row_init_nxt = 1'b0;
          cand_len_nxt = cand_len_r + DW'(1);
          state_nxt    = last_r ? ST_RDRES : ST_IDLE;
        end else begin
          idx_nxt = idx_r + DW'(1);
        end
      end

      ST_RDRES: begin
        dp_raddr  = query_len_r;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        // Hold the read data until the output register is free.
        dp_re = 1'b0;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.distance = dist_ext[DIST_W-1:0];
          out_data_nxt.overflow = ovf_r;
          row_init_nxt          = 1'b1;
          cand_len_nxt          = '0;
          ovf_nxt               = query_over_r;
          state_nxt             = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      row_init_r   <= 1'b1;
      cand_len_r   <= '0;
      ovf_r        <= 1'b0;
      query_len_r  <= '0;
      query_open_r <= 1'b0;
      query_over_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_init_r   <= row_init_nxt;
      cand_len_r   <= cand_len_nxt;
      ovf_r        <= ovf_nxt;
      query_len_r  <= query_len_nxt;
      query_open_r <= query_open_nxt;
      query_over_r <= query_over_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    left_r     <= left_nxt;
    diag_r     <= diag_nxt;
    ch_r       <= ch_nxt;
    last_r     <= last_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/lev_chk.sv -----
module lev_chk import lev_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input lev_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input lev_out_t out_data
);

  // A result waiting for the sink keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An overflowed result always reports the saturated distance.
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.distance == DIST_W'(MAX_LEN))
    else $error("overflow without saturated distance");

  // After the beat ending a candidate is taken, the input is not ready.
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == OP_CAND) && in_data.last |=> !in_ready)
    else $error("input open while a candidate is finishing");

  // Reset leaves no result pending.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind levenshtein_edit_distance lev_chk #(
  .MAX_LEN (MAX_LEN)
) u_lev_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
